// ===== rtl/smq_pkg.sv =====
package smq_pkg;

   localparam int SLOTS   = 64;
   localparam int QUEUES  = 4;

   // slot address, and slot index with room for the null code (SLOTS)
   localparam int SLOT_AW = $clog2(SLOTS);
   localparam int IDX_W   = $clog2(SLOTS + 1);
   localparam int QIDX_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;

   localparam logic [IDX_W-1:0] NIL = IDX_W'(SLOTS);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic               req_type;
      logic [1:0]         queue_id;
      logic signed [31:0] push_value;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] pop_value;
   } rsp_word_type;

   typedef struct packed {
      logic start;   // take the request: issue reads, store push data
      logic finish;  // commit list updates and load the result
      logic reject;  // load the refusal result for the request
   } cmd_type;

   typedef struct packed {
      logic go;      // request at the input can be carried out
   } sts_type;

   function automatic logic is_slot(input logic [IDX_W-1:0] idx);
      return idx < IDX_W'(SLOTS);
   endfunction

   // link value of a slot never written since reset: chain to the next slot
   function automatic logic [IDX_W-1:0] link_reset(input logic [SLOT_AW-1:0] addr);
      return IDX_W'(addr) + IDX_W'(1);
   endfunction

endpackage

// ===== rtl/smq_ram.sv =====
module smq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic                     re,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/smq_ctrl.sv =====
module smq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  smq_pkg::sts_type  sts,
   output smq_pkg::cmd_type  cmd
);
   import smq_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WORK = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_busy;
   logic take;

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || out_busy;
   assign take      = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.finish = 1'b0;
      cmd.reject = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (sts.go) begin
                  cmd.start = 1'b1;
                  state_in  = S_WORK;
               end else begin
                  cmd.reject = 1'b1;
               end
            end
         end
         S_WORK: begin
            // hold until the output register can take the result
            if (!out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.finish || cmd.reject) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/smq_datapath.sv =====
module smq_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  smq_pkg::req_word_type req_word,
   input  smq_pkg::cmd_type      cmd,
   output smq_pkg::sts_type      sts,
   output smq_pkg::rsp_word_type rsp_word
);
   import smq_pkg::*;

   logic [IDX_W-1:0]  head_ff [QUEUES];
   logic [IDX_W-1:0]  head_in [QUEUES];
   logic [IDX_W-1:0]  tail_ff [QUEUES];
   logic [IDX_W-1:0]  tail_in [QUEUES];
   logic [IDX_W-1:0]  free_head_ff, free_head_in;
   logic [SLOTS-1:0]  link_vld_ff, link_vld_in;

   logic              op_ff;
   logic [QIDX_W-1:0] q_ff;
   logic [IDX_W-1:0]  slot_ff;
   rsp_word_type      rsp_ff, rsp_in;

   logic              q_ok;
   logic [QIDX_W-1:0] req_q;
   logic [IDX_W-1:0]  head_sel;
   logic [IDX_W-1:0]  start_slot;

   logic [SLOT_AW-1:0] link_addr;
   logic               link_we;
   logic [IDX_W-1:0]   link_wdata;
   logic [IDX_W-1:0]   link_q;
   logic [IDX_W-1:0]   link_val;
   logic               link_wr_need;
   logic [SLOT_AW-1:0] link_wr_addr;

   logic               data_we;
   logic               data_re;
   logic [31:0]        data_q;

   assign q_ok     = (32'(req_word.queue_id) < QUEUES);
   assign req_q    = QIDX_W'(req_word.queue_id);
   assign head_sel = head_ff[req_q];

   assign sts.go = q_ok && ((req_word.req_type == OP_PUSH) ? is_slot(free_head_ff)
                                                           : is_slot(head_sel));

   assign start_slot = (req_word.req_type == OP_PUSH) ? free_head_ff : head_sel;

   // unwritten links read as the reset chain
   assign link_val = link_vld_ff[slot_ff[SLOT_AW-1:0]] ? link_q
                                                       : link_reset(slot_ff[SLOT_AW-1:0]);

   // push appends behind the tail; pop returns its slot to the free list
   always_comb begin
      if (op_ff == OP_PUSH) begin
         link_wr_need = is_slot(head_ff[q_ff]) && is_slot(tail_ff[q_ff]);
         link_wr_addr = tail_ff[q_ff][SLOT_AW-1:0];
         link_wdata   = slot_ff;
      end else begin
         link_wr_need = 1'b1;
         link_wr_addr = slot_ff[SLOT_AW-1:0];
         link_wdata   = free_head_ff;
      end
   end

   assign link_we   = cmd.finish && link_wr_need;
   assign link_addr = cmd.finish ? link_wr_addr : start_slot[SLOT_AW-1:0];
   assign data_we   = cmd.start && (req_word.req_type == OP_PUSH);
   assign data_re   = cmd.start && (req_word.req_type == OP_POP);

   smq_ram #(
      .WIDTH (IDX_W),
      .DEPTH (SLOTS)
   ) u_link_ram (
      .clock (clock),
      .addr  (link_addr),
      .we    (link_we),
      .re    (cmd.start),
      .wdata (link_wdata),
      .rdata (link_q)
   );

   smq_ram #(
      .WIDTH (32),
      .DEPTH (SLOTS)
   ) u_data_ram (
      .clock (clock),
      .addr  (start_slot[SLOT_AW-1:0]),
      .we    (data_we),
      .re    (data_re),
      .wdata (req_word.push_value),
      .rdata (data_q)
   );

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_head_in = free_head_ff;
      link_vld_in  = link_vld_ff;
      if (link_we) begin
         link_vld_in[link_wr_addr] = 1'b1;
      end
      if (cmd.finish) begin
         if (op_ff == OP_PUSH) begin
            free_head_in = link_val;
            if (!is_slot(head_ff[q_ff])) begin
               head_in[q_ff] = slot_ff;
            end
            tail_in[q_ff] = slot_ff;
         end else begin
            // the tail slot's link is never written on push: end the list here
            head_in[q_ff] = (slot_ff == tail_ff[q_ff]) ? NIL : link_val;
            free_head_in  = slot_ff;
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in.status    = ST_OK;
         rsp_in.pop_value = (op_ff == OP_POP) ? data_q : '0;
      end else if (cmd.reject) begin
         if (req_word.req_type == OP_PUSH) begin
            rsp_in.status    = ST_FULL;
            rsp_in.pop_value = '0;
         end else begin
            rsp_in.status    = ST_EMPTY;
            rsp_in.pop_value = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUES; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
         end
         free_head_ff <= '0;
         link_vld_ff  <= '0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_head_ff <= free_head_in;
         link_vld_ff  <= link_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff   <= req_word.req_type;
         q_ff    <= req_q;
         slot_ff <= start_slot;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_word = rsp_ff;

endmodule

// ===== rtl/shared_buffer_multi_queue_core.sv =====
// Several FIFO queues sharing one 64-slot store through per-slot links and a
// free list. A push or pop that succeeds reads the link store, a single-port
// RAM, when the request is taken (next free slot, or next element of the queue)
// and writes it as the request finishes. A refused request (store full, empty
// queue, queue number out of range) skips the work state. Results go to an
// output register, so a new request is taken once the control is idle and that
// register is free or being drained. No clearing pass is needed after reset.
module shared_buffer_multi_queue_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  smq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output smq_pkg::rsp_word_type rsp_word
);
   import smq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   smq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   smq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_word (rsp_word)
   );

endmodule

// ===== sim/shared_buffer_multi_queue_core_test.sv =====
`timescale 1ns / 1ps

module shared_buffer_multi_queue_core_test;
   import smq_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   // predicted copy of the list state
   logic signed [31:0] data_mem [SLOTS];
   logic [IDX_W-1:0]   link_mem [SLOTS];
   logic [IDX_W-1:0]   head_q [QUEUES];
   logic [IDX_W-1:0]   tail_q [QUEUES];
   logic [IDX_W-1:0]   free_ptr;

   rsp_word_type results_due[$];
   int           errors = 0;
   int           idle_count = 0;
   bit           req_idle = 1'b1;
   bit           rsp_idle = 1'b1;
   int           rsp_hold = 0;

   shared_buffer_multi_queue_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sh0000_0000;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_word_type make_word(logic op, logic [1:0] q, logic signed [31:0] v);
      req_word_type w;
      w.req_type = op;
      w.queue_id = q;
      w.push_value = v;
      return w;
   endfunction

   task automatic reset_list_model();
      for (int i = 0; i < SLOTS; i++) begin
         data_mem[i] = '0;
         link_mem[i] = IDX_W'(i + 1);
      end
      for (int i = 0; i < QUEUES; i++) begin
         head_q[i] = NIL;
         tail_q[i] = NIL;
      end
      free_ptr = '0;
   endtask

   function automatic rsp_word_type predict_queue_op(req_word_type w);
      rsp_word_type       r;
      logic [SLOT_AW-1:0] slot;
      int                 q;
      q = int'(w.queue_id);
      if (w.req_type == OP_PUSH) begin
         r.status = ST_FULL;
         r.pop_value = '0;
         if (q < QUEUES && free_ptr < SLOTS) begin
            slot = free_ptr[SLOT_AW-1:0];
            free_ptr = link_mem[slot];
            // a stale tail behind a null head is ignored
            if (head_q[q] >= SLOTS)
               head_q[q] = IDX_W'(slot);
            else if (tail_q[q] < SLOTS)
               link_mem[tail_q[q][SLOT_AW-1:0]] = IDX_W'(slot);
            link_mem[slot] = NIL;
            tail_q[q] = IDX_W'(slot);
            data_mem[slot] = w.push_value;
            r.status = ST_OK;
         end
      end else begin
         r.status = ST_EMPTY;
         r.pop_value = -32'sd1;
         if (q < QUEUES && head_q[q] < SLOTS) begin
            slot = head_q[q][SLOT_AW-1:0];
            head_q[q] = link_mem[slot];
            link_mem[slot] = free_ptr;
            free_ptr = IDX_W'(slot);
            r.status = ST_OK;
            r.pop_value = data_mem[slot];
         end
      end
      return r;
   endfunction

   // offer one word, hold it until taken, then log its result
   task automatic send_word(req_word_type w);
      int gap;
      gap = req_idle ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      results_due.push_back(predict_queue_op(w));
   endtask

   task automatic send_push(logic [1:0] q, logic signed [31:0] v);
      send_word(make_word(OP_PUSH, q, v));
   endtask

   task automatic send_pop(logic [1:0] q);
      send_word(make_word(OP_POP, q, $urandom));
   endtask

   task automatic test_directed();
      for (int q = 0; q < QUEUES; q++) send_pop(q[1:0]);
      send_push(2'd0, 32'sh8000_0000);
      send_push(2'd0, 32'sh7fff_ffff);
      send_push(2'd1, 32'sh0000_0000);
      send_push(2'd2, -32'sd1);
      send_push(2'd3, 32'sh5555_5555);
      send_push(2'd3, 32'shaaaa_aaaa);
      send_pop(2'd0);
      send_pop(2'd0);
      send_pop(2'd0);
      // queue 0 now has a stale tail
      send_push(2'd0, 32'sd123);
      send_pop(2'd0);
      send_pop(2'd1);
      send_pop(2'd2);
      send_pop(2'd3);
      send_pop(2'd3);
      send_pop(2'd3);
   endtask

   // stall the receiver first, fill the whole store, overflow it, then pop
   task automatic test_fill_and_drain();
      rsp_hold = HOLD_CYCLES;
      for (int i = 0; i < SLOTS + 3; i++)
         send_push(2'($urandom_range(0, QUEUES - 1)), pick_value());
      for (int i = 0; i < SLOTS + 6; i++)
         send_pop(2'($urandom_range(0, QUEUES - 1)));
      for (int q = 0; q < QUEUES; q++) send_pop(q[1:0]);
   endtask

   task automatic test_sender_pause();
      for (int i = 0; i < 20; i++)
         send_word(make_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                             pick_value()));
      // drop valid so the last word is not offered again while waiting
      @(negedge clock);
      req_valid <= 1'b0;
      wait (results_due.size() == 0);
      for (int i = 0; i < 20; i++)
         send_word(make_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                             pick_value()));
   endtask

   task automatic test_random_traffic();
      int          push_pct;
      logic [1:0]  q;
      for (int batch = 0; batch < 12; batch++) begin
         case (batch % 4)
            0: begin req_idle = 1'b1; rsp_idle = 1'b1; end
            1: begin req_idle = 1'b1; rsp_idle = 1'b0; end
            2: begin req_idle = 1'b0; rsp_idle = 1'b1; end
            default: begin req_idle = 1'b0; rsp_idle = 1'b0; end
         endcase
         // alternate filling, draining and mixed stretches
         case (batch % 3)
            0: push_pct = 80;
            1: push_pct = 20;
            default: push_pct = 50;
         endcase
         for (int i = 0; i < 90; i++) begin
            q = ($urandom_range(0, 3) == 0) ? 2'd1 : 2'($urandom_range(0, QUEUES - 1));
            if ($urandom_range(0, 99) < push_pct)
               send_push(q, pick_value());
            else
               send_pop(q);
         end
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   // result receiver stall
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (rsp_idle) begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
               rsp_stall <= 1'b1;
               stall_left--;
            end else begin
               rsp_stall <= 1'b0;
            end
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            $error("unexpected result: status %0d pop_value %0d",
                   rsp_word.status, rsp_word.pop_value);
            errors++;
         end else begin
            exp_rsp = results_due.pop_front();
            if (rsp_word.status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_word.status);
               errors++;
            end
            if (rsp_word.pop_value !== exp_rsp.pop_value) begin
               $error("pop_value: expected %0d, got %0d",
                      exp_rsp.pop_value, rsp_word.pop_value);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= IDLE_LIMIT) begin
            $display("shared_buffer_multi_queue_core_test: FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      reset_list_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_drain();
      test_sender_pause();
      test_random_traffic();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (results_due.size() == 0);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("shared_buffer_multi_queue_core_test: PASS");
      else
         $display("shared_buffer_multi_queue_core_test: FAIL");
      $finish;
   end

endmodule
